/* hdl/trace_staging_ring_flusher_top_macros.svh */
// Assertion macros for the trace staging ring flusher.
`ifndef TRACE_STAGING_RING_FLUSHER_TOP_MACROS_SVH
`define TRACE_STAGING_RING_FLUSHER_TOP_MACROS_SVH

// Invariant checked at every edge outside reset.
`define TSRF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TSRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tsrf_pkg.sv */
// Types and constants shared by the trace staging ring flusher.
package tsrf_pkg;

    localparam int STAGING_DEPTH_DEF = 32;
    localparam int MAX_RING_ENTRIES  = 65536;

    localparam logic [15:0] MARKER_NODE = 16'hFFFF;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAPH_T0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 3'd4;

    localparam logic ACT_EMIT  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_FLUSH,
        ST_END
    } state_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] event_code;
        logic [15:0] node;
        logic [31:0] aux_a;
        logic [31:0] aux_b;
    } entry_t;

endpackage

/* hdl/trace_staging_ring_flusher_top.sv */
// Trace staging store with flush of staged words into an external ring.
// Emit: accepted while idle, no result unless the store reaches one free slot.
// Full flush: busy through the start marker write, one staging memory read
//   per entry and the end marker write; results follow the reads in the next cycle.
// Final flush of N staged words: one result per cycle, registered behind the ST_FLUSH reads.
// Reset clears control registers, count and cursor; the staging memory and read data are not cleared.
`include "trace_staging_ring_flusher_top_macros.svh"

module trace_staging_ring_flusher_top
    import tsrf_pkg::*;
#(
    parameter int STAGING_DEPTH = STAGING_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [31:0]          cycle_now,
    input  logic [15:0]          event_in,
    input  logic [15:0]          node_in,
    input  logic [31:0]          aux_a_in,
    input  logic [31:0]          aux_b_in,
    output logic                 strobe,
    output logic [15:0]          ring_slot,
    output logic [31:0]          stamp,
    output logic [15:0]          event_out,
    output logic [15:0]          node_out,
    output logic [31:0]          aux_a_out,
    output logic [31:0]          aux_b_out,
    output logic [31:0]          cursor_out,
    output logic                 last_of_flush
);

    localparam int IDX_W = $clog2(STAGING_DEPTH);
    localparam int CNT_W = $clog2(STAGING_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(STAGING_DEPTH);
    localparam logic [CNT_W-1:0] CNT_TRIG   = CNT_W'(STAGING_DEPTH - 2);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(STAGING_DEPTH - 1);
    localparam logic [31:0]      DEPTH_WORD = 32'(STAGING_DEPTH);
    localparam logic [16:0]      RING_MAX   = 17'(MAX_RING_ENTRIES);

    // configuration
    logic        trace_on_reg;
    logic [16:0] ring_entries_reg;
    logic [31:0] graph_start_reg;
    logic [15:0] start_code_reg;
    logic [15:0] end_code_reg;

    // control and datapath state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      cursor_reg, cursor_next;
    logic [31:0]      cur_new_reg, cur_new_next;
    logic [31:0]      mstamp_reg, mstamp_next;
    logic             full_reg, full_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // output pipe behind the memory read
    logic        vld_reg;
    logic [15:0] slot_reg;
    logic        last_reg;
    entry_t      rdata_reg;

    entry_t mem [STAGING_DEPTH];

    logic             accept, enabled, emit, fin, full_hit, last_rd;
    logic [31:0]      stamp_now;
    logic [16:0]      size_clamped, mask_full;
    logic [15:0]      slot_calc;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    assign accept    = start && !busy;
    assign enabled   = trace_on_reg && (ring_entries_reg != 17'd0);
    assign emit      = accept && enabled && (action == ACT_EMIT);
    assign fin       = accept && enabled && (action == ACT_FLUSH) && (count_reg != '0);
    assign full_hit  = emit && (count_reg == CNT_TRIG);
    assign stamp_now = cycle_now - graph_start_reg;
    assign last_rd   = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;

    assign size_clamped = (ring_entries_reg > RING_MAX) ? RING_MAX : ring_entries_reg;
    assign mask_full    = size_clamped - 17'd1;
    assign slot_calc    = (cursor_reg[15:0] + 16'(rd_idx_reg)) & mask_full[15:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_on_reg     <= 1'b0;
            ring_entries_reg <= '0;
            graph_start_reg  <= '0;
            start_code_reg   <= '0;
            end_code_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_TRACE_ON:   trace_on_reg     <= cfg_wdata[0];
                CFG_RING_SIZE:  ring_entries_reg <= cfg_wdata[16:0];
                CFG_GRAPH_T0:   graph_start_reg  <= cfg_wdata;
                CFG_START_CODE: start_code_reg   <= cfg_wdata[15:0];
                CFG_END_CODE:   end_code_reg     <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (full_hit)
                    state_next = ST_START;
                else if (fin)
                    state_next = ST_FLUSH;
            end
            ST_START: state_next = ST_FLUSH;
            ST_FLUSH:
            begin
                if (last_rd)
                    state_next = full_reg ? ST_END : ST_IDLE;
            end
            ST_END:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine: handshake and memory port
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = '{stamp: stamp_now, event_code: event_in, node: node_in,
                      aux_a: aux_a_in, aux_b: aux_b_in};
        unique case (state_reg)
            ST_IDLE:
            begin
                busy   = 1'b0;
                mem_we = emit && (count_reg < CNT_FULL);
            end
            ST_START:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_LAST;
                mem_wdata = '{stamp: mstamp_reg, event_code: start_code_reg,
                              node: MARKER_NODE, aux_a: DEPTH_WORD, aux_b: cursor_reg};
            end
            ST_FLUSH:
            begin
                mem_re = 1'b1;
            end
            ST_END:
            begin
                // cursor_reg already holds the advanced cursor here
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{stamp: mstamp_reg, event_code: end_code_reg,
                              node: MARKER_NODE, aux_a: DEPTH_WORD, aux_b: cursor_reg};
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        cur_new_next = cur_new_reg;
        mstamp_next  = mstamp_reg;
        full_next    = full_reg;
        rd_idx_next  = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (emit)
                begin
                    mstamp_next = stamp_now;
                    full_next   = full_hit;
                    if (count_reg < CNT_FULL)
                        count_next = count_reg + CNT_W'(1);
                end
                else if (fin)
                begin
                    full_next    = 1'b0;
                    cur_new_next = cursor_reg + 32'(count_reg);
                end
            end
            ST_START:
            begin
                count_next   = CNT_FULL;
                cur_new_next = cursor_reg + DEPTH_WORD;
            end
            ST_FLUSH:
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
                if (last_rd)
                begin
                    count_next  = '0;
                    cursor_next = cur_new_reg;
                end
            end
            ST_END:
            begin
                count_next = CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            cur_new_reg <= '0;
            mstamp_reg  <= '0;
            full_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            vld_reg     <= 1'b0;
            slot_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            cur_new_reg <= cur_new_next;
            mstamp_reg  <= mstamp_next;
            full_reg    <= full_next;
            rd_idx_reg  <= rd_idx_next;
            vld_reg     <= mem_re;
            slot_reg    <= slot_calc;
            last_reg    <= mem_re && last_rd;
        end
    end

    // staging memory; the state machine never reads and writes the same entry
    // in one cycle, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= mem[rd_idx_reg];
    end

    assign strobe        = vld_reg;
    assign ring_slot     = slot_reg;
    assign stamp         = rdata_reg.stamp;
    assign event_out     = rdata_reg.event_code;
    assign node_out      = rdata_reg.node;
    assign aux_a_out     = rdata_reg.aux_a;
    assign aux_b_out     = rdata_reg.aux_b;
    assign cursor_out    = cur_new_reg;
    assign last_of_flush = last_reg;

    `TSRF_ASSERT(a_count_bound, count_reg <= CNT_FULL, "staged count above depth")
    `TSRF_ASSERT_IMP(a_strobe_src, strobe, $past(state_reg == ST_FLUSH), "word without read")
    `TSRF_ASSERT_IMP(a_last_strobe, last_of_flush, strobe, "last flag without word")
    `TSRF_ASSERT_IMP(a_rd_in_range, state_reg == ST_FLUSH, CNT_W'(rd_idx_reg) < count_reg,
        "flush read past staged count")
    `TSRF_ASSERT_NXT(a_start_to_flush, state_reg == ST_START, state_reg == ST_FLUSH,
        "start marker not followed by flush")

endmodule
